[hw/rtl/dtt_pkg.sv]
// Shared types and constants of the deadline timer table.
`default_nettype none

package dtt_pkg;

   // Word codes carried in req_tuser.
   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_ADJUST = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_TICK   = 3'd3,
      KIND_QUERY  = 3'd4
   } kind_type;

   localparam int KIND_W     = 3;
   localparam int HANDLE_W   = 6;
   localparam int TIMEOUT_W  = 20;
   localparam int TIME_W     = 32;

   // Number of handles the handle field can address.
   localparam int HANDLE_SPAN = 64;

   // Deadlines saturate at the top of the time range.
   localparam logic [TIME_W-1:0] TOP_TIME = '1;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

endpackage

`default_nettype wire

[hw/rtl/dtt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module dtt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/deadline_timer_table_unit.sv]
// Top level of the deadline timer table: handle flags, deadline memory and scan sequencer.
`default_nettype none

// The block keeps one deadline per timer handle. Each request word on the
// req_ channel carries a kind in req_tuser and a handle, a timeout and the
// current time in req_tdata. Add arms a handle at now plus timeout (saturated
// at the top of the time range), adjust does the same for a registered
// handle only, and delete unregisters a handle; these three return no
// response word. A query returns one word with the earliest armed deadline.
// A tick returns every armed handle whose deadline is at or before now,
// earliest deadline first and lowest handle first on ties, each handle
// disarmed as it goes out; tlast marks the final word of the tick, and a
// tick with nothing due returns one word with both valid flags low.
// Deadlines live in a RAM with a registered read; query and tick find their
// answer by reading all stored entries (at most 64) in turn. Each response
// word is found by a pass through ST_SCAN and ST_LAST and loaded in ST_EMIT,
// and each further word of a tick starts a new pass from handle zero. The
// next request is taken in the cycle after the final load. Requests are
// taken only while no scan runs. A stalled receiver holds the output word
// steady and holds the scan, and with it the request side, before its next
// load. Reset clears all flags at once; the block is ready after reset falls.
module deadline_timer_table_unit import dtt_pkg::*; #(
   parameter int HANDLES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: handle [5:0], timeout [25:6], now [57:26], zero fill [63:58]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: kind [2:0]
   input  wire logic [KIND_W-1:0]     req_tuser,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // rsp_tdata: expired_handle [5:0], expired_valid [6], next_deadline [38:7],
   //            next_valid [39]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready
);

   // Handles beyond the field's reach are never addressed, so storage stops there.
   localparam int DEPTH = (HANDLES < HANDLE_SPAN) ? HANDLES : HANDLE_SPAN;
   localparam int IW    = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_LAST = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [DEPTH-1:0]        registered_ff, registered_in;
   logic [DEPTH-1:0]        armed_ff, armed_in;
   logic                    is_tick_ff, is_tick_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [IW-1:0]           addr_ff, addr_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IW-1:0]           rd_idx_ff, rd_idx_in;
   logic                    found_ff, found_in;
   logic                    more_ff, more_in;
   logic [IW-1:0]           best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]       best_dl_ff, best_dl_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Request word fields.
   kind_type                req_kind;
   logic [HANDLE_W-1:0]     req_handle;
   logic [TIMEOUT_W-1:0]    req_timeout;
   logic [TIME_W-1:0]       req_now;
   logic                    req_accept;
   logic                    handle_ok;
   logic [IW-1:0]           handle_idx;
   logic [TIME_W:0]         deadline_sum;
   logic [TIME_W-1:0]       deadline_new;
   logic                    mem_we;
   logic [TIME_W-1:0]       rd_data;

   // Scan compare and response load.
   logic                    cand;
   logic                    better;
   logic                    rsp_load;
   logic                    tick_hit;

   assign req_kind    = kind_type'(req_tuser);
   assign req_handle  = req_tdata[5:0];
   assign req_timeout = req_tdata[25:6];
   assign req_now     = req_tdata[57:26];

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;

   assign handle_ok    = {1'b0, req_handle} < 7'(DEPTH);
   assign handle_idx   = req_handle[IW-1:0];
   assign deadline_sum = {1'b0, req_now} + (TIME_W + 1)'(req_timeout);
   assign deadline_new = deadline_sum[TIME_W] ? TOP_TIME : deadline_sum[TIME_W-1:0];

   // Only add and a valid adjust write a deadline; scans never overlap a write.
   assign mem_we = req_accept && handle_ok &&
                   ((req_kind == KIND_ADD) ||
                    ((req_kind == KIND_ADJUST) && registered_ff[handle_idx]));

   dtt_ram #(
      .WIDTH (TIME_W),
      .DEPTH (DEPTH)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (handle_idx),
      .wr_data (deadline_new),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // An entry competes when armed and, for a tick, already due. Scanning in
   // ascending order with a strict compare keeps the lowest handle on ties.
   assign cand   = rd_valid_ff && armed_ff[rd_idx_ff] &&
                   (!is_tick_ff || (rd_data <= now_ff));
   assign better = cand && (!found_ff || (rd_data < best_dl_ff));

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign tick_hit = is_tick_ff && found_ff;

   always_comb begin
      state_in      = state_ff;
      registered_in = registered_ff;
      armed_in      = armed_ff;
      is_tick_in    = is_tick_ff;
      now_in        = now_ff;
      addr_in       = addr_ff;
      rd_valid_in   = (state_ff == ST_SCAN);
      rd_idx_in     = addr_ff;
      found_in      = found_ff | cand;
      more_in       = more_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (better) begin
         best_idx_in = rd_idx_ff;
         best_dl_in  = rd_data;
      end
      // A second due entry means the word now being found is not the tick's last.
      if (cand && found_ff && is_tick_ff) begin
         more_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_kind) inside
                  KIND_ADD: begin
                     if (handle_ok) begin
                        registered_in[handle_idx] = 1'b1;
                        armed_in[handle_idx]      = 1'b1;
                     end
                  end
                  KIND_ADJUST: begin
                     if (handle_ok && registered_ff[handle_idx]) begin
                        armed_in[handle_idx] = 1'b1;
                     end
                  end
                  KIND_DELETE: begin
                     if (handle_ok) begin
                        registered_in[handle_idx] = 1'b0;
                        armed_in[handle_idx]      = 1'b0;
                     end
                  end
                  KIND_TICK, KIND_QUERY: begin
                     state_in   = ST_SCAN;
                     is_tick_in = (req_kind == KIND_TICK);
                     now_in     = req_now;
                     addr_in    = '0;
                     found_in   = 1'b0;
                     more_in    = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == IW'(DEPTH - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(!is_tick_ff && found_ff),
                               ((!is_tick_ff && found_ff) ? best_dl_ff : '0),
                               tick_hit,
                               (tick_hit ? HANDLE_W'(best_idx_ff) : '0)};
               rsp_last_in  = !(tick_hit && more_ff);
               if (tick_hit) begin
                  armed_in[best_idx_ff] = 1'b0;
               end
               if (tick_hit && more_ff) begin
                  state_in = ST_SCAN;
                  addr_in  = '0;
                  found_in = 1'b0;
                  more_in  = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         registered_ff <= '0;
         armed_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         registered_ff <= registered_in;
         armed_ff      <= armed_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_tick_ff  <= is_tick_in;
      now_ff      <= now_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      found_ff    <= found_in;
      more_ff     <= more_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[hw/rtl/dtt_checker.sv]
// Port-level assertions for the deadline timer table, bound to the top level.
`default_nettype none

module dtt_checker import dtt_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready
);

   // A stalled response word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word withdrawn while stalled");

   // No response word is offered right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("response word offered after reset");

   // An expiry word carries no deadline answer.
   a_expiry_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> !rsp_tdata[39] && (rsp_tdata[38:7] == '0))
      else $error("expiry word carries a deadline");

   // Query answers and empty ticks are always single words.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> rsp_tlast && (rsp_tdata[5:0] == '0))
      else $error("non-expiry word is not a final word");

endmodule

bind deadline_timer_table_unit dtt_checker u_dtt_checker (.*);

`default_nettype wire
